// ===== rtl/core/dusr_pkg.sv =====
// Shared constants, codes and types for the DFA unreachable state removal block.
package dusr_pkg;

  localparam int MAX_STATES  = 64;
  localparam int MAX_SYMBOLS = 16;

  localparam int STATE_W = $clog2(MAX_STATES);
  localparam int SYM_W   = $clog2(MAX_SYMBOLS);
  localparam int CNT_W   = STATE_W + 1;
  localparam int SYMC_W  = SYM_W + 1;
  localparam int TBL_AW  = STATE_W + SYM_W;
  localparam int ENTRY_W = STATE_W + 1;

  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_RUN   = 2'd1;
  localparam logic [1:0] FUNC_MAP   = 2'd2;
  localparam logic [1:0] FUNC_RED   = 2'd3;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_RANGE   = 2'd1;
  localparam logic [1:0] STATUS_NOT_RUN = 2'd2;

  localparam logic [1:0] REG_STATE_COUNT   = 2'd0;
  localparam logic [1:0] REG_SYMBOL_COUNT  = 2'd1;
  localparam logic [1:0] REG_INITIAL_STATE = 2'd2;

  typedef enum logic [11:0] {
    ST_CLEAR = 12'b000000000001,
    ST_IDLE  = 12'b000000000010,
    ST_POP   = 12'b000000000100,
    ST_LOAD  = 12'b000000001000,
    ST_RDT   = 12'b000000010000,
    ST_CHK   = 12'b000000100000,
    ST_NUM   = 12'b000001000000,
    ST_MAP   = 12'b000010000000,
    ST_N2O   = 12'b000100000000,
    ST_TBL   = 12'b001000000000,
    ST_O2N   = 12'b010000000000,
    ST_DONE  = 12'b100000000000
  } seq_state_t;

endpackage

// ===== rtl/core/dusr_ram.sv =====
// Simple dual-port RAM with one write port and one registered read port.
module dusr_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/dfa_unreachable_state_removal.sv =====
// Top level of the DFA unreachable state removal block with its sequencer.
//
// The input channel carries one command per transfer: write a table entry, run the
// reduction, read the old-to-new mapping of a state, or read one entry of the
// reduced table. Every command gives exactly one result transfer on the output
// channel. The APB port sets the state count, symbol count and initial state; the
// user must write it only while the block is idle; the block does not enforce it.
// After reset the block sweeps the 1024-entry transition table to mark every entry
// undefined, and only then raises in_ready.
// A run visits the table entries of every reachable state through the single table
// read port, then renumbers the states.
// One command is in flight at a time. in_ready rises again as soon as a result has
// moved into the output register, so the next command can be worked on while that
// result waits for out_ready; the sequencer then holds its own result until the
// output register is free.
module dfa_unreachable_state_removal
  import dusr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         func,
  input  logic [STATE_W-1:0] state_index,
  input  logic [SYM_W-1:0]   symbol,
  input  logic [STATE_W-1:0] target_state,
  input  logic               target_defined,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic [CNT_W-1:0]   removed_count,
  output logic [CNT_W-1:0]   kept_count,
  output logic [STATE_W-1:0] new_initial,
  output logic [STATE_W-1:0] result_index,
  output logic               result_valid
);

  seq_state_t state;

  logic [CNT_W-1:0]      state_count;
  logic [SYMC_W-1:0]     symbol_count;
  logic [STATE_W-1:0]    initial_state;
  logic [CNT_W-1:0]      eff_states;
  logic [SYMC_W-1:0]     eff_symbols;

  logic [TBL_AW-1:0]     clr_addr;
  logic [CNT_W-1:0]      run_states;
  logic [SYMC_W-1:0]     run_symbols;
  logic                  results_ready;
  logic [CNT_W-1:0]      removed_total;
  logic [CNT_W-1:0]      kept_total;
  logic [STATE_W-1:0]    new_init;
  logic [MAX_STATES-1:0] flags;
  logic [CNT_W-1:0]      sp;
  logic [STATE_W-1:0]    cur;
  logic [SYM_W-1:0]      r;
  logic [STATE_W-1:0]    s;
  logic [CNT_W-1:0]      kept;
  logic [CNT_W-1:0]      kept_next;
  logic [SYM_W-1:0]      sym_q;
  logic [1:0]            pend_status;
  logic [STATE_W-1:0]    pend_res;
  logic                  pend_valid;

  logic                  accept;
  logic                  cfg_write;
  logic                  out_free;
  logic                  wr_ok;
  logic                  hit;
  logic                  red_hit;
  logic [STATE_W-1:0]    tgt;

  logic                  tbl_we;
  logic [TBL_AW-1:0]     tbl_waddr;
  logic [ENTRY_W-1:0]    tbl_wdata;
  logic [TBL_AW-1:0]     tbl_raddr;
  logic [ENTRY_W-1:0]    tbl_rdata;
  logic                  stk_we;
  logic [STATE_W-1:0]    stk_waddr;
  logic [STATE_W-1:0]    stk_wdata;
  logic [STATE_W-1:0]    stk_raddr;
  logic [STATE_W-1:0]    stk_rdata;
  logic                  num_we;
  logic [STATE_W-1:0]    o2n_raddr;
  logic [STATE_W-1:0]    o2n_rdata;
  logic [STATE_W-1:0]    n2o_rdata;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  always_comb begin
    if (state_count == '0) begin
      eff_states = CNT_W'(1);
    end else if (state_count > CNT_W'(MAX_STATES)) begin
      eff_states = CNT_W'(MAX_STATES);
    end else begin
      eff_states = state_count;
    end
    if (symbol_count == '0) begin
      eff_symbols = SYMC_W'(1);
    end else if (symbol_count > SYMC_W'(MAX_SYMBOLS)) begin
      eff_symbols = SYMC_W'(MAX_SYMBOLS);
    end else begin
      eff_symbols = symbol_count;
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_STATE_COUNT:   prdata = {{(32-CNT_W){1'b0}}, state_count};
      REG_SYMBOL_COUNT:  prdata = {{(32-SYMC_W){1'b0}}, symbol_count};
      REG_INITIAL_STATE: prdata = {{(32-STATE_W){1'b0}}, initial_state};
      default:           prdata = '0;
    endcase
  end

  assign wr_ok = ({1'b0, state_index} < eff_states) && ({1'b0, symbol} < eff_symbols);
  assign tgt   = tbl_rdata[STATE_W-1:0];
  assign hit   = tbl_rdata[STATE_W] && ({1'b0, tgt} < run_states) && !flags[tgt];
  assign red_hit = tbl_rdata[STATE_W] && ({1'b0, tgt} < run_states) && flags[tgt];
  assign kept_next = flags[s] ? kept + CNT_W'(1) : kept;

  always_comb begin
    if (state == ST_CLEAR) begin
      tbl_we    = 1'b1;
      tbl_waddr = clr_addr;
      tbl_wdata = '0;
    end else begin
      tbl_we    = accept && (func == FUNC_WRITE) && wr_ok;
      tbl_waddr = {state_index, symbol};
      tbl_wdata = target_defined ? {1'b1, target_state} : '0;
    end
    tbl_raddr = (state == ST_N2O) ? {n2o_rdata, sym_q} : {cur, r};
    if (state == ST_CHK) begin
      stk_we    = hit;
      stk_waddr = sp[STATE_W-1:0];
      stk_wdata = tgt;
    end else begin
      stk_we    = accept && (func == FUNC_RUN);
      stk_waddr = '0;
      stk_wdata = initial_state;
    end
    stk_raddr = STATE_W'(sp - CNT_W'(1));
    num_we    = (state == ST_NUM) && flags[s];
    o2n_raddr = (state == ST_TBL) ? tgt : state_index;
  end

  dusr_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_STATES * MAX_SYMBOLS)) u_table (
    .clk(clk), .we(tbl_we), .waddr(tbl_waddr), .wdata(tbl_wdata),
    .raddr(tbl_raddr), .rdata(tbl_rdata)
  );

  dusr_ram #(.WIDTH(STATE_W), .DEPTH(MAX_STATES)) u_stack (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata)
  );

  dusr_ram #(.WIDTH(STATE_W), .DEPTH(MAX_STATES)) u_old_to_new (
    .clk(clk), .we(num_we), .waddr(s), .wdata(kept[STATE_W-1:0]),
    .raddr(o2n_raddr), .rdata(o2n_rdata)
  );

  dusr_ram #(.WIDTH(STATE_W), .DEPTH(MAX_STATES)) u_new_to_old (
    .clk(clk), .we(num_we), .waddr(kept[STATE_W-1:0]), .wdata(s),
    .raddr(state_index), .rdata(n2o_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clr_addr      <= '0;
      state_count   <= CNT_W'(1);
      symbol_count  <= SYMC_W'(1);
      initial_state <= '0;
      results_ready <= 1'b0;
      removed_total <= '0;
      kept_total    <= '0;
      new_init      <= '0;
      run_states    <= '0;
      run_symbols   <= '0;
      flags         <= '0;
      sp            <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_write) begin
        unique case (paddr[3:2])
          REG_STATE_COUNT: begin
            state_count   <= pwdata[CNT_W-1:0];
            results_ready <= 1'b0;
          end
          REG_SYMBOL_COUNT: begin
            symbol_count  <= pwdata[SYMC_W-1:0];
            results_ready <= 1'b0;
          end
          REG_INITIAL_STATE: begin
            initial_state <= pwdata[STATE_W-1:0];
            results_ready <= 1'b0;
          end
          default: begin
          end
        endcase
      end
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + TBL_AW'(1);
          if (clr_addr == '1) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            sym_q       <= symbol;
            pend_status <= STATUS_OK;
            pend_res    <= '0;
            pend_valid  <= 1'b0;
            state       <= ST_DONE;
            unique case (func)
              FUNC_WRITE: begin
                if (wr_ok) begin
                  results_ready <= 1'b0;
                end else begin
                  pend_status <= STATUS_RANGE;
                end
              end
              FUNC_RUN: begin
                if ({1'b0, initial_state} >= eff_states) begin
                  pend_status <= STATUS_RANGE;
                end else begin
                  run_states  <= eff_states;
                  run_symbols <= eff_symbols;
                  flags       <= MAX_STATES'(1) << initial_state;
                  sp          <= CNT_W'(1);
                  state       <= ST_POP;
                end
              end
              FUNC_MAP: begin
                if (!results_ready) begin
                  pend_status <= STATUS_NOT_RUN;
                end else if ({1'b0, state_index} >= run_states) begin
                  pend_status <= STATUS_RANGE;
                end else if (flags[state_index]) begin
                  state <= ST_MAP;
                end
              end
              default: begin
                if (!results_ready) begin
                  pend_status <= STATUS_NOT_RUN;
                end else if (({1'b0, state_index} >= kept_total) ||
                             ({1'b0, symbol} >= run_symbols)) begin
                  pend_status <= STATUS_RANGE;
                end else begin
                  state <= ST_N2O;
                end
              end
            endcase
          end
        end
        ST_POP: begin
          if (sp == '0) begin
            s     <= '0;
            kept  <= '0;
            state <= ST_NUM;
          end else begin
            sp    <= sp - CNT_W'(1);
            state <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          cur   <= stk_rdata;
          r     <= '0;
          state <= ST_RDT;
        end
        ST_RDT: begin
          state <= ST_CHK;
        end
        ST_CHK: begin
          if (hit) begin
            flags[tgt] <= 1'b1;
            sp         <= sp + CNT_W'(1);
          end
          if (({1'b0, r} + SYMC_W'(1)) == run_symbols) begin
            state <= ST_POP;
          end else begin
            r     <= r + SYM_W'(1);
            state <= ST_RDT;
          end
        end
        ST_NUM: begin
          if (flags[s] && (s == initial_state)) begin
            new_init <= kept[STATE_W-1:0];
          end
          kept <= kept_next;
          s    <= s + STATE_W'(1);
          if (({1'b0, s} + CNT_W'(1)) == run_states) begin
            kept_total    <= kept_next;
            removed_total <= run_states - kept_next;
            results_ready <= 1'b1;
            state         <= ST_DONE;
          end
        end
        ST_MAP: begin
          pend_res   <= o2n_rdata;
          pend_valid <= 1'b1;
          state      <= ST_DONE;
        end
        ST_N2O: begin
          state <= ST_TBL;
        end
        ST_TBL: begin
          state <= red_hit ? ST_O2N : ST_DONE;
        end
        ST_O2N: begin
          pend_res   <= o2n_rdata;
          pend_valid <= 1'b1;
          state      <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && out_free) begin
      status <= pend_status;
      if ((pend_status == STATUS_OK) && results_ready) begin
        removed_count <= removed_total;
        kept_count    <= kept_total;
        new_initial   <= new_init;
      end else begin
        removed_count <= '0;
        kept_count    <= '0;
        new_initial   <= '0;
      end
      if (pend_status == STATUS_OK) begin
        result_index <= pend_res;
        result_valid <= pend_valid;
      end else begin
        result_index <= '0;
        result_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== dv/dusr_checker.sv =====
// Checker for the DFA unreachable state removal block: tracks registers, predicts and compares.
module dusr_checker
  import dusr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         func,
  input  logic [STATE_W-1:0] state_index,
  input  logic [SYM_W-1:0]   symbol,
  input  logic [STATE_W-1:0] target_state,
  input  logic               target_defined,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [1:0]         status,
  input  logic [CNT_W-1:0]   removed_count,
  input  logic [CNT_W-1:0]   kept_count,
  input  logic [STATE_W-1:0] new_initial,
  input  logic [STATE_W-1:0] result_index,
  input  logic               result_valid,
  output int                 errors,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]         status;
    logic [CNT_W-1:0]   removed;
    logic [CNT_W-1:0]   kept;
    logic [STATE_W-1:0] new_init;
    logic [STATE_W-1:0] index;
    logic               valid;
  } reduce_result_t;

  reduce_result_t     pending_results[$];
  logic [ENTRY_W-1:0] trans_tbl[MAX_STATES*MAX_SYMBOLS];
  logic               reach[MAX_STATES];
  logic [STATE_W-1:0] old2new[MAX_STATES];
  logic [STATE_W-1:0] new2old[MAX_STATES];
  logic               have_results;
  int                 removed_n, kept_n, init_n, run_ns, run_nr;
  int                 cfg_states, cfg_symbols, cfg_init;

  assign pending = pending_results.size();

  function automatic int eff_states();
    if (cfg_states == 0) return 1;
    if (cfg_states > MAX_STATES) return MAX_STATES;
    return cfg_states;
  endfunction

  function automatic int eff_symbols();
    if (cfg_symbols == 0) return 1;
    if (cfg_symbols > MAX_SYMBOLS) return MAX_SYMBOLS;
    return cfg_symbols;
  endfunction

  function automatic int next_state(int s, int r);
    logic [ENTRY_W-1:0] e;
    e = trans_tbl[s*MAX_SYMBOLS + r];
    if (!e[STATE_W] || int'(e[STATE_W-1:0]) >= run_ns) return -1;
    return int'(e[STATE_W-1:0]);
  endfunction

  task automatic reduce_automaton(input int ns, input int nr, input int init);
    logic [STATE_W-1:0] stack[MAX_STATES];
    int sp, cur, t, kept;
    run_ns = ns;
    run_nr = nr;
    foreach (reach[k]) reach[k] = 1'b0;
    reach[init] = 1'b1;
    stack[0] = STATE_W'(init);
    sp = 1;
    while (sp > 0) begin
      sp--;
      cur = stack[sp];
      for (int r = 0; r < nr; r++) begin
        t = next_state(cur, r);
        if (t >= 0 && !reach[t]) begin
          reach[t] = 1'b1;
          stack[sp] = STATE_W'(t);
          sp++;
        end
      end
    end
    kept = 0;
    for (int s = 0; s < ns; s++) begin
      if (reach[s]) begin
        old2new[s] = STATE_W'(kept);
        new2old[kept] = STATE_W'(s);
        kept++;
      end
    end
    kept_n = kept;
    removed_n = ns - kept;
    init_n = old2new[init];
    have_results = 1'b1;
  endtask

  task automatic predict_command();
    reduce_result_t r;
    int t;
    r = '0;
    case (func)
      FUNC_WRITE: begin
        if (state_index >= eff_states() || symbol >= eff_symbols()) begin
          r.status = STATUS_RANGE;
        end else begin
          trans_tbl[state_index*MAX_SYMBOLS + symbol] =
            target_defined ? {1'b1, target_state} : '0;
          have_results = 1'b0;
        end
      end
      FUNC_RUN: begin
        if (cfg_init >= eff_states()) r.status = STATUS_RANGE;
        else reduce_automaton(eff_states(), eff_symbols(), cfg_init);
      end
      default: begin
        if (!have_results) begin
          r.status = STATUS_NOT_RUN;
        end else if (func == FUNC_MAP) begin
          if (state_index >= run_ns) begin
            r.status = STATUS_RANGE;
          end else if (reach[state_index]) begin
            r.index = old2new[state_index];
            r.valid = 1'b1;
          end
        end else begin
          if (state_index >= kept_n || symbol >= run_nr) begin
            r.status = STATUS_RANGE;
          end else begin
            t = next_state(new2old[state_index], symbol);
            if (t >= 0 && reach[t]) begin
              r.index = old2new[t];
              r.valid = 1'b1;
            end
          end
        end
      end
    endcase
    if (r.status == STATUS_OK && have_results) begin
      r.removed = CNT_W'(removed_n);
      r.kept = CNT_W'(kept_n);
      r.new_init = STATE_W'(init_n);
    end
    pending_results.insert(pending_results.size(), r);
  endtask

  task automatic report(input string what, input int exp_v, input int act_v);
    errors++;
    if (errors <= 10)
      $display("%0t mismatch on %s: expected %0d, got %0d", $time, what, exp_v, act_v);
  endtask

  task automatic check_result();
    reduce_result_t e;
    if (pending_results.size() == 0) begin
      errors++;
      if (errors <= 10) $display("%0t result transfer with nothing outstanding", $time);
      return;
    end
    e = pending_results.pop_front();
    if (status !== e.status) report("status", e.status, status);
    if (removed_count !== e.removed) report("removed_count", e.removed, removed_count);
    if (kept_count !== e.kept) report("kept_count", e.kept, kept_count);
    if (new_initial !== e.new_init) report("new_initial", e.new_init, new_initial);
    if (result_index !== e.index) report("result_index", e.index, result_index);
    if (result_valid !== e.valid) report("result_valid", e.valid, result_valid);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      foreach (trans_tbl[k]) trans_tbl[k] = '0;
      foreach (reach[k]) reach[k] = 1'b0;
      have_results = 1'b0;
      removed_n = 0;
      kept_n = 0;
      init_n = 0;
      run_ns = 0;
      run_nr = 0;
      cfg_states = 1;
      cfg_symbols = 1;
      cfg_init = 0;
      errors = 0;
      pending_results.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_STATE_COUNT:   begin cfg_states = pwdata[6:0];  have_results = 1'b0; end
          REG_SYMBOL_COUNT:  begin cfg_symbols = pwdata[4:0]; have_results = 1'b0; end
          REG_INITIAL_STATE: begin cfg_init = pwdata[5:0];    have_results = 1'b0; end
          default: ;
        endcase
      end
      if (out_valid && out_ready) check_result();
      if (in_valid && in_ready) predict_command();
    end
  end
endmodule

// ===== dv/tb_top.sv =====
// Top of the testbench: clock, reset, register setup, command stimulus and verdict.
module tb_top;
  import dusr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         func = FUNC_WRITE;
  logic [STATE_W-1:0] state_index = '0;
  logic [SYM_W-1:0]   symbol = '0;
  logic [STATE_W-1:0] target_state = '0;
  logic               target_defined = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         status;
  logic [CNT_W-1:0]   removed_count, kept_count;
  logic [STATE_W-1:0] new_initial, result_index;
  logic               result_valid;
  int                 errors, pending;
  int                 n_cmds = 0, n_runs = 0, n_phases = 0;
  int                 cur_states = 1, cur_symbols = 1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  dfa_unreachable_state_removal dut (.*);

  dusr_checker chk (.*);

  initial begin
    #100ms;
    $display("timeout waiting for the block");
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int k;
    wait (!rst);
    forever begin
      k = $urandom_range(0, 6);
      if (k > 0) begin
        @(posedge clk);
        out_ready <= 1'b0;
        repeat (k) @(posedge clk);
      end else begin
        @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(negedge clk); while (!(out_valid && out_ready));
    end
  end

  task automatic send(input logic [1:0] f, input int i, input int s, input int t,
                      input logic d);
    int gap;
    gap = $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    func <= f;
    state_index <= STATE_W'(i);
    symbol <= SYM_W'(s);
    target_state <= STATE_W'(t);
    target_defined <= d;
    in_valid <= 1'b1;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    n_cmds++;
    if (f == FUNC_RUN) n_runs++;
  endtask

  task automatic apb_write(input logic [1:0] reg_id, input int value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_id, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic configure(input int sc, input int syc, input int init);
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
    apb_write(REG_STATE_COUNT, sc);
    apb_write(REG_SYMBOL_COUNT, syc);
    apb_write(REG_INITIAL_STATE, init);
    cur_states = (sc == 0) ? 1 : (sc > MAX_STATES) ? MAX_STATES : sc;
    cur_symbols = (syc == 0) ? 1 : (syc > MAX_SYMBOLS) ? MAX_SYMBOLS : syc;
    n_phases++;
  endtask

  task automatic random_command();
    int sel, i, s, t;
    sel = $urandom_range(0, 99);
    if ($urandom_range(0, 9) == 0) begin
      send(2'($urandom_range(0, 3)), $urandom_range(0, 63), $urandom_range(0, 15),
           $urandom_range(0, 63), 1'($urandom_range(0, 1)));
      return;
    end
    i = $urandom_range(0, cur_states - 1);
    s = $urandom_range(0, cur_symbols - 1);
    t = $urandom_range(0, cur_states - 1);
    if (sel < 45) send(FUNC_WRITE, i, s, t, $urandom_range(0, 5) != 0);
    else if (sel < 53) send(FUNC_RUN, i, s, t, 1'b0);
    else if (sel < 75) send(FUNC_MAP, i, s, t, 1'b0);
    else send(FUNC_RED, i, s, t, 1'b0);
  endtask

  initial begin
    int len, sc, syc, init;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send(FUNC_MAP, 0, 0, 0, 1'b0);
    send(FUNC_RED, 0, 0, 0, 1'b0);
    send(FUNC_RUN, 0, 0, 0, 1'b0);
    send(FUNC_MAP, 0, 0, 0, 1'b0);
    send(FUNC_WRITE, 0, 0, 0, 1'b1);
    send(FUNC_WRITE, 63, 15, 63, 1'b1);
    send(FUNC_MAP, 0, 0, 0, 1'b0);
    send(FUNC_RUN, 0, 0, 0, 1'b0);
    send(FUNC_RED, 0, 0, 0, 1'b0);
    send(FUNC_RED, 1, 0, 0, 1'b0);
    send(FUNC_RED, 0, 15, 0, 1'b0);
    send(FUNC_MAP, 1, 0, 0, 1'b0);
    send(FUNC_WRITE, 0, 0, 63, 1'b0);
    send(FUNC_RUN, 0, 0, 0, 1'b0);
    send(FUNC_RED, 0, 0, 0, 1'b0);
    send(FUNC_WRITE, 0, 0, 5, 1'b1);
    send(FUNC_RUN, 0, 0, 0, 1'b0);
    send(FUNC_RED, 0, 0, 0, 1'b0);

    while (n_cmds < 1900) begin
      case (n_phases % 8)
        0: begin sc = 64;  syc = 16; init = 0;  end
        1: begin sc = 64;  syc = 16; init = 63; end
        2: begin sc = 0;   syc = 0;  init = 0;  end
        3: begin sc = 127; syc = 31; init = 5;  end
        4: begin sc = 8;   syc = 4;  init = 9;  end
        default: begin
          sc = $urandom_range(1, 20);
          syc = $urandom_range(1, 6);
          init = $urandom_range(0, sc - 1);
        end
      endcase
      configure(sc, syc, init);
      len = (cur_states * cur_symbols > 200) ? 80 : $urandom_range(60, 150);
      repeat (len) random_command();
    end

    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (50) @(posedge clk);
    $display("Sent %0d commands including %0d reductions across %0d register settings.",
             n_cmds, n_runs, n_phases);
    $display("Mismatches: %0d, results still outstanding: %0d.", errors, pending);
    if (errors == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

// ===== files.f =====
rtl/core/dusr_pkg.sv
rtl/core/dusr_ram.sv
rtl/core/dfa_unreachable_state_removal.sv
dv/dusr_checker.sv
dv/tb_top.sv
